### rtl/cmct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cmct_pkg;

   localparam logic [31:0] DIST_EMPTY = 32'hFFFF_FFFF;
   localparam logic [31:0] TIME_NEVER = 32'hFFFF_FF00;
   localparam logic [16:0] HOPS_NONE  = 17'h1_FFFF;

   typedef enum logic [1:0] {
      OP_OFFER  = 2'd0,
      OP_COMMIT = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OFFER,
      ST_READ,
      ST_WALK,
      ST_LAST
   } state_type;

   typedef struct packed {
      logic        mark;
      logic [16:0] hops;
      logic [31:0] distance;
   } pend_word_type;

   typedef struct packed {
      logic [16:0] hops;
      logic [31:0] distance;
      logic [31:0] stamp;
   } comm_word_type;

   typedef struct packed {
      logic [31:0] rd_time;
      logic [31:0] distance;
      logic [16:0] hops;
      logic [12:0] count;
      logic        accepted;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/cmct_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cmct_ram #(
   parameter int WIDTH = 50,
   parameter int DEPTH = 4096
) (
   input  wire                      clock,
   input  wire                      wen,
   input  wire [$clog2(DEPTH)-1:0]  waddr,
   input  wire [WIDTH-1:0]          wdata,
   input  wire                      ren,
   input  wire [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
      if (ren) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/cmct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cmct_ctrl
   import cmct_pkg::*;
#(
   parameter int NUM_CELLS = 4096
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [1:0]                    req_op,
   input  wire [11:0]                   req_cell,
   input  wire [31:0]                   req_dist,
   input  wire [15:0]                   req_hops,
   input  wire [31:0]                   req_time,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output rsp_type                      rsp,
   output logic                         p_wen,
   output logic [$clog2(NUM_CELLS)-1:0] p_waddr,
   output pend_word_type                p_wdata,
   output logic                         p_ren,
   output logic [$clog2(NUM_CELLS)-1:0] p_raddr,
   input  pend_word_type                p_rdata,
   output logic                         c_wen,
   output logic [$clog2(NUM_CELLS)-1:0] c_waddr,
   output comm_word_type                c_wdata,
   output logic                         c_ren,
   output logic [$clog2(NUM_CELLS)-1:0] c_raddr,
   input  comm_word_type                c_rdata
);

   localparam int AW = $clog2(NUM_CELLS);
   localparam int CW = $clog2(NUM_CELLS + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(NUM_CELLS - 1);

   state_type     state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          walk_vld_ff, walk_vld_in;
   logic [AW-1:0] walk_addr_ff, walk_addr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] count_nxt;
   logic [AW-1:0] cell_ff, cell_in;
   logic [31:0]   dist_ff, dist_in;
   logic [15:0]   hops_ff, hops_in;
   logic [31:0]   time_ff, time_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          in_range;
   logic          count_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         walk_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         walk_vld_ff  <= walk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_addr_ff <= walk_addr_in;
      count_ff     <= count_in;
      cell_ff      <= cell_in;
      dist_ff      <= dist_in;
      hops_ff      <= hops_in;
      time_ff      <= time_in;
      rsp_ff       <= rsp_in;
   end

   assign in_range  = 32'(req_cell) < 32'(NUM_CELLS);
   assign count_inc = walk_vld_ff && p_rdata.mark;
   assign count_nxt = count_ff + CW'(count_inc);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      walk_vld_in  = 1'b0;
      walk_addr_in = idx_ff;
      count_in     = count_ff;
      cell_in      = cell_ff;
      dist_in      = dist_ff;
      hops_in      = hops_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      p_wen        = 1'b0;
      p_waddr      = cell_ff;
      p_wdata      = '0;
      p_ren        = 1'b0;
      p_raddr      = AW'(req_cell);
      c_wen        = 1'b0;
      c_waddr      = walk_addr_ff;
      c_wdata      = '0;
      c_ren        = 1'b0;
      c_raddr      = AW'(req_cell);

      // write back marked cells of a commit walk
      if ((state_ff == ST_WALK || state_ff == ST_LAST) && count_inc) begin
         p_wen            = 1'b1;
         p_waddr          = walk_addr_ff;
         p_wdata.mark     = 1'b0;
         p_wdata.hops     = p_rdata.hops;
         p_wdata.distance = DIST_EMPTY;
         c_wen            = 1'b1;
         c_waddr          = walk_addr_ff;
         c_wdata.hops     = p_rdata.hops;
         c_wdata.distance = p_rdata.distance;
         c_wdata.stamp    = time_ff;
         count_in         = count_nxt;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            p_wen            = 1'b1;
            p_waddr          = idx_ff;
            p_wdata.mark     = 1'b0;
            p_wdata.hops     = HOPS_NONE;
            p_wdata.distance = DIST_EMPTY;
            c_wen            = 1'b1;
            c_waddr          = idx_ff;
            c_wdata.hops     = HOPS_NONE;
            c_wdata.distance = '0;
            c_wdata.stamp    = TIME_NEVER;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cell_in = AW'(req_cell);
               dist_in = req_dist;
               hops_in = req_hops;
               time_in = req_time;
               rsp_in  = '0;
               unique case (op_type'(req_op))
                  OP_OFFER: begin
                     if (in_range) begin
                        p_ren    = 1'b1;
                        state_in = ST_OFFER;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (in_range) begin
                        c_ren    = 1'b1;
                        state_in = ST_READ;
                     end else begin
                        rsp_in.hops    = HOPS_NONE;
                        rsp_in.rd_time = TIME_NEVER;
                        rsp_valid_in   = 1'b1;
                     end
                  end
                  OP_COMMIT: begin
                     idx_in   = '0;
                     count_in = '0;
                     state_in = ST_WALK;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_OFFER: begin
            if (dist_ff < p_rdata.distance) begin
               p_wen            = 1'b1;
               p_waddr          = cell_ff;
               p_wdata.mark     = 1'b1;
               p_wdata.hops     = {1'b0, hops_ff};
               p_wdata.distance = dist_ff;
               rsp_in.accepted  = 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_READ: begin
            rsp_in.hops     = c_rdata.hops;
            rsp_in.distance = c_rdata.distance;
            rsp_in.rd_time  = c_rdata.stamp;
            rsp_valid_in    = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_WALK: begin
            p_ren        = 1'b1;
            p_raddr      = idx_ff;
            walk_vld_in  = 1'b1;
            walk_addr_in = idx_ff;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_LAST;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_LAST: begin
            rsp_in.count = 13'(count_nxt);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

### rtl/per_cell_min_distance_commit_table.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  ports               content
// req       in         req_tvalid/tready   tuser: operation; tdata: cell, distance, hops, time
// rsp       out        rsp_tvalid/tready   tdata: accepted, count, hops, distance, time
//
// Offer and read: the table read is registered first, then the result is registered
// after the compare and write back (offer) or from the table data (read).
// Commit: walks the pending table one cell a cycle, then reports the committed count.
// Out-of-range cells and unknown operations answer in the cycle after they are taken.
// After reset a clearing pass writes every cell of both tables; req_tready stays low.
// One transaction in flight; req_tready drops while a result waits and is not taken.

module per_cell_min_distance_commit_table
   import cmct_pkg::*;
#(
   parameter int NUM_CELLS = 4096
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [1:0] operation
   input  wire  [1:0]  req_tuser,
   // [11:0] cell_req, [43:12] distance, [59:44] hop_count, [91:60] current_time
   input  wire  [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [0] accepted, [13:1] committed_count, [30:14] read_hops,
   // [62:31] read_distance, [94:63] read_time
   output logic [95:0] rsp_tdata
);

   localparam int AW = $clog2(NUM_CELLS);

   rsp_type       rsp;
   logic          p_wen, p_ren, c_wen, c_ren;
   logic [AW-1:0] p_waddr, p_raddr, c_waddr, c_raddr;
   pend_word_type p_wdata, p_rdata;
   comm_word_type c_wdata, c_rdata;

   cmct_ctrl #(
      .NUM_CELLS (NUM_CELLS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_cell  (req_tdata[11:0]),
      .req_dist  (req_tdata[43:12]),
      .req_hops  (req_tdata[59:44]),
      .req_time  (req_tdata[91:60]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp),
      .p_wen     (p_wen),
      .p_waddr   (p_waddr),
      .p_wdata   (p_wdata),
      .p_ren     (p_ren),
      .p_raddr   (p_raddr),
      .p_rdata   (p_rdata),
      .c_wen     (c_wen),
      .c_waddr   (c_waddr),
      .c_wdata   (c_wdata),
      .c_ren     (c_ren),
      .c_raddr   (c_raddr),
      .c_rdata   (c_rdata)
   );

   cmct_ram #(
      .WIDTH ($bits(pend_word_type)),
      .DEPTH (NUM_CELLS)
   ) u_pend_ram (
      .clock (clock),
      .wen   (p_wen),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .ren   (p_ren),
      .raddr (p_raddr),
      .rdata (p_rdata)
   );

   cmct_ram #(
      .WIDTH ($bits(comm_word_type)),
      .DEPTH (NUM_CELLS)
   ) u_comm_ram (
      .clock (clock),
      .wen   (c_wen),
      .waddr (c_waddr),
      .wdata (c_wdata),
      .ren   (c_ren),
      .raddr (c_raddr),
      .rdata (c_rdata)
   );

   assign rsp_tdata = {1'b0, rsp};

endmodule

`default_nettype wire

### rtl/cmct_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cmct_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [95:0] rsp_tdata
);

   // tables are being cleared right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing pass");

   // one transaction in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (!req_tready || (rsp_tvalid && rsp_tready)))
      else $error("second request taken before result");

   // an operation fills only its own result fields
   a_fields_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((!rsp_tdata[0] || rsp_tdata[95:1] == 95'd0) &&
                      (rsp_tdata[13:1] == 13'd0 ||
                       (rsp_tdata[95:14] == 82'd0 && !rsp_tdata[0]))))
      else $error("result mixes fields of different operations");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result dropped or changed");

endmodule

bind per_cell_min_distance_commit_table cmct_checker u_checker (.*);

`default_nettype wire
